>>> hdl/squared_distance_bucket_queue_defines.svh
// ----------------------------------------------------------------------------
// Squared distance bucket queue assertion macros
// Assertion helpers used by the queue RTL; they expand to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef SQUARED_DISTANCE_BUCKET_QUEUE_DEFINES_SVH
`define SQUARED_DISTANCE_BUCKET_QUEUE_DEFINES_SVH

`ifndef SYNTH
`define SDBQ_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");
`define SDBQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define SDBQ_ASSERT_NEVER(lbl, clk, rst, expr)
`define SDBQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hdl/sdbq_pkg.sv
// ----------------------------------------------------------------------------
// Squared distance bucket queue package
// Sizes, codes, state types and helpers shared by the queue modules.
// ----------------------------------------------------------------------------
`default_nettype none
package sdbq_pkg;

  localparam int MAX_DIST    = 32;
  localparam int CAPACITY    = 1024;
  localparam int COORD_BITS  = 12;
  localparam int PRIO_SPAN   = 2 * MAX_DIST * MAX_DIST + 1;
  localparam int NUM_BUCKETS = ((MAX_DIST + 1) * (MAX_DIST + 2)) / 2;
  localparam int PRIO_W      = 12;
  localparam int TAB_W       = $clog2(PRIO_SPAN);
  localparam int DIST_W      = $clog2(MAX_DIST + 1);
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int BIT_W       = 5;
  localparam int WORD_BITS   = 1 << BIT_W;
  localparam int BMP_WORDS   = (NUM_BUCKETS + WORD_BITS - 1) / WORD_BITS;
  localparam int BMP_W       = BKT_W - BIT_W;
  localparam int POINT_W     = 2 * COORD_BITS;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PRIO  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    Q_INIT,
    Q_IDLE,
    Q_PUSH_LOOK,
    Q_PUSH_LINK,
    Q_POP_SCAN,
    Q_POP_HEAD,
    Q_POP_DONE,
    Q_DONE
  } q_state_t;

  typedef enum logic [1:0] {
    TAB_CLEAR,
    TAB_FILL,
    TAB_READY
  } tab_phase_t;

  typedef struct packed {
    logic              en;
    logic [TAB_W-1:0]  addr;
  } tab_req_t;

  typedef struct packed {
    logic              valid;
    logic [BKT_W-1:0]  id;
  } tab_rsp_t;

  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  idx;
  } first_set_t;

  function automatic first_set_t first_set(input logic [WORD_BITS-1:0] w);
    first_set_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r.found = 1'b1;
        r.idx   = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/sdbq_table.sv
// ----------------------------------------------------------------------------
// Priority to bucket table
// Builds the priority lookup memory after reset and serves registered lookups.
// ----------------------------------------------------------------------------
`default_nettype none
module sdbq_table import sdbq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire tab_req_t req,
  output tab_rsp_t      rsp,
  output logic          ready
);

  logic [BKT_W:0] tab_mem [PRIO_SPAN];

  tab_phase_t        phase, phase_next;
  logic [TAB_W-1:0]  clr;
  logic [DIST_W-1:0] px, py;
  logic [BKT_W-1:0]  n;
  logic              wr_en;
  logic [TAB_W-1:0]  wr_addr;
  logic [BKT_W:0]    wr_data;
  logic [PRIO_W-1:0] sq_sum;
  logic              fill_last;

  assign sq_sum    = PRIO_W'(PRIO_W'(px) * PRIO_W'(px) + PRIO_W'(py) * PRIO_W'(py));
  assign fill_last = (px == DIST_W'(MAX_DIST)) && (py == px);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      TAB_CLEAR: if (clr == TAB_W'(PRIO_SPAN - 1)) phase_next = TAB_FILL;
      TAB_FILL:  if (fill_last) phase_next = TAB_READY;
      TAB_READY: phase_next = TAB_READY;
      default:   phase_next = TAB_CLEAR;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr;
    wr_data = '0;
    ready   = 1'b0;
    unique case (phase)
      TAB_CLEAR: wr_en = 1'b1;
      TAB_FILL: begin
        wr_en   = 1'b1;
        wr_addr = TAB_W'(sq_sum);
        wr_data = {1'b1, n};
      end
      TAB_READY: ready = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= TAB_CLEAR;
      clr   <= '0;
      px    <= '0;
      py    <= '0;
      n     <= '0;
    end else begin
      phase <= phase_next;
      if (phase == TAB_CLEAR) clr <= clr + 1'b1;
      if (phase == TAB_FILL) begin
        n <= n + 1'b1;
        if (py == px) begin
          px <= px + 1'b1;
          py <= '0;
        end else begin
          py <= py + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) tab_mem[wr_addr] <= wr_data;
    if (req.en) {rsp.valid, rsp.id} <= tab_mem[req.addr];
  end

endmodule
`default_nettype wire

>>> hdl/squared_distance_bucket_queue.sv
// ----------------------------------------------------------------------------
// Squared distance bucket queue
// Bucketed priority queue of grid points keyed by squared distance.
// ----------------------------------------------------------------------------
// After reset the block builds its priority table and clears its bucket
// bitmap, and takes no word until then. A push does a table lookup, then
// bucket, bitmap and free list reads, then the write back. A pop scans the
// 32-bucket bitmap words, up to 18 of them, then does a bucket read and a
// link and point read. One word is in work at a time; a finished result waits
// in the output register while the next word is accepted.
`default_nettype none
`include "squared_distance_bucket_queue_defines.svh"
module squared_distance_bucket_queue import sdbq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // prio[11:0], point_x[23:12], point_y[35:24]
  input  wire logic [0:0]  s_tuser,  // op[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // out_x[11:0], out_y[23:12], held[34:24]
  output logic [1:0]       m_tuser   // status[1:0]
);

  logic [WORD_BITS-1:0] bmp_mem  [BMP_WORDS];
  logic [2*SLOT_W-1:0]  bkt_mem  [NUM_BUCKETS];
  logic [CNT_W-1:0]     link_mem [CAPACITY];
  logic [POINT_W-1:0]   pts_mem  [CAPACITY];

  q_state_t state, state_next;
  tab_req_t tab_req;
  tab_rsp_t tab_rsp;
  logic     tab_ready;

  logic [COORD_BITS-1:0] x_r, y_r;
  status_t               err_r;
  logic [BKT_W-1:0]      id_r, cur, low_bucket;
  logic [SLOT_W-1:0]     slot_r;
  logic                  from_free;
  logic [CNT_W-1:0]      free_head, fresh_next, held_count;
  logic [WORD_BITS-1:0]  word_r;
  logic [BMP_W-1:0]      clr;

  logic                  bmp_re, bmp_we, bkt_re, bkt_we, link_re, link_we, pts_re, pts_we;
  logic [BMP_W-1:0]      bmp_ra, bmp_wa;
  logic [WORD_BITS-1:0]  bmp_wd, bmp_q;
  logic [BKT_W-1:0]      bkt_ra, bkt_wa;
  logic [2*SLOT_W-1:0]   bkt_wd, bkt_q;
  logic [SLOT_W-1:0]     link_ra, link_wa, pts_wa;
  logic [CNT_W-1:0]      link_wd, link_q;
  logic [POINT_W-1:0]    pts_q;

  logic                  accept, out_free, emit;
  status_t               emit_status;
  logic [COORD_BITS-1:0] emit_x, emit_y;
  logic [CNT_W-1:0]      emit_held;
  first_set_t            fs;
  logic [SLOT_W-1:0]     pop_head, pop_tail;
  logic                  push_nonempty;

  assign accept        = s_tvalid && s_tready;
  assign out_free      = !m_tvalid || m_tready;
  assign fs            = first_set(bmp_q & ({WORD_BITS{1'b1}} << cur[BIT_W-1:0]));
  assign pop_head      = bkt_q[2*SLOT_W-1:SLOT_W];
  assign pop_tail      = bkt_q[SLOT_W-1:0];
  assign push_nonempty = bmp_q[id_r[BIT_W-1:0]];

  sdbq_table u_table (
    .clk   (clk),
    .rst   (rst),
    .req   (tab_req),
    .rsp   (tab_rsp),
    .ready (tab_ready)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      Q_INIT: if (tab_ready) state_next = Q_IDLE;
      Q_IDLE: begin
        if (accept) begin
          if (s_tuser[0] == OP_POP) begin
            state_next = (held_count == '0) ? Q_DONE : Q_POP_SCAN;
          end else begin
            state_next = (s_tdata[11:0] >= PRIO_W'(PRIO_SPAN)) ? Q_DONE : Q_PUSH_LOOK;
          end
        end
      end
      Q_PUSH_LOOK: begin
        if (!tab_rsp.valid || held_count == CNT_W'(CAPACITY)) state_next = Q_DONE;
        else state_next = Q_PUSH_LINK;
      end
      Q_PUSH_LINK: if (out_free) state_next = Q_IDLE;
      Q_POP_SCAN: begin
        if (fs.found) state_next = Q_POP_HEAD;
        else if (cur[BKT_W-1:BIT_W] == BMP_W'(BMP_WORDS - 1)) state_next = Q_DONE;
      end
      Q_POP_HEAD: state_next = Q_POP_DONE;
      Q_POP_DONE: if (out_free) state_next = Q_IDLE;
      Q_DONE:     if (out_free) state_next = Q_IDLE;
      default:    state_next = Q_INIT;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    tab_req.en  = 1'b0;
    tab_req.addr = TAB_W'(s_tdata[11:0]);
    bmp_re  = 1'b0;  bmp_ra  = id_r[BKT_W-1:BIT_W];
    bmp_we  = 1'b0;  bmp_wa  = clr;  bmp_wd = '0;
    bkt_re  = 1'b0;  bkt_ra  = id_r;
    bkt_we  = 1'b0;  bkt_wa  = id_r; bkt_wd = '0;
    link_re = 1'b0;  link_ra = free_head[SLOT_W-1:0];
    link_we = 1'b0;  link_wa = pop_tail; link_wd = '0;
    pts_re  = 1'b0;  pts_we  = 1'b0; pts_wa = slot_r;
    emit        = 1'b0;
    emit_status = err_r;
    emit_x      = '0;
    emit_y      = '0;
    emit_held   = held_count;
    unique case (state)
      Q_INIT: bmp_we = (clr < BMP_W'(BMP_WORDS));
      Q_IDLE: begin
        s_tready   = 1'b1;
        tab_req.en = accept && (s_tdata[11:0] < PRIO_W'(PRIO_SPAN));
        bmp_re     = accept;
        bmp_ra     = low_bucket[BKT_W-1:BIT_W];
      end
      Q_PUSH_LOOK: begin
        bmp_re  = 1'b1;
        bmp_ra  = tab_rsp.id[BKT_W-1:BIT_W];
        bkt_re  = 1'b1;
        bkt_ra  = tab_rsp.id;
        link_re = 1'b1;
      end
      Q_PUSH_LINK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_status = ST_OK;
          emit_held = held_count + 1'b1;
          pts_we    = 1'b1;
          link_we   = push_nonempty;
          link_wd   = {1'b0, slot_r};
          bkt_we    = 1'b1;
          bkt_wd    = {push_nonempty ? pop_head : slot_r, slot_r};
          bmp_we    = 1'b1;
          bmp_wa    = id_r[BKT_W-1:BIT_W];
          bmp_wd    = bmp_q | (WORD_BITS'(1) << id_r[BIT_W-1:0]);
        end
      end
      Q_POP_SCAN: begin
        if (fs.found) begin
          bkt_re = 1'b1;
          bkt_ra = {cur[BKT_W-1:BIT_W], fs.idx};
        end else begin
          bmp_re = 1'b1;
          bmp_ra = cur[BKT_W-1:BIT_W] + 1'b1;
        end
      end
      Q_POP_HEAD: begin
        link_re = 1'b1;
        link_ra = pop_head;
        pts_re  = 1'b1;
      end
      Q_POP_DONE: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = ST_OK;
          emit_x      = pts_q[COORD_BITS-1:0];
          emit_y      = pts_q[POINT_W-1:COORD_BITS];
          emit_held   = held_count - 1'b1;
          link_we     = 1'b1;
          link_wa     = pop_head;
          link_wd     = free_head;
          if (pop_head == pop_tail) begin
            bmp_we = 1'b1;
            bmp_wa = cur[BKT_W-1:BIT_W];
            bmp_wd = word_r & ~(WORD_BITS'(1) << cur[BIT_W-1:0]);
          end else begin
            bkt_we = 1'b1;
            bkt_wa = cur;
            bkt_wd = {link_q[SLOT_W-1:0], pop_tail};
          end
        end
      end
      Q_DONE: emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= Q_INIT;
      clr        <= '0;
      free_head  <= CNT_W'(CAPACITY);
      fresh_next <= '0;
      low_bucket <= '1;
      held_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == Q_INIT && clr < BMP_W'(BMP_WORDS)) clr <= clr + 1'b1;
      if (emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (emit) held_count <= emit_held;
      if (state == Q_PUSH_LINK && out_free) begin
        if (from_free) free_head <= link_q;
        else fresh_next <= fresh_next + 1'b1;
        if (id_r < low_bucket) low_bucket <= id_r;
      end
      if (state == Q_POP_HEAD) low_bucket <= cur;
      if (state == Q_POP_DONE && out_free) free_head <= {1'b0, pop_head};
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tuser <= emit_status;
      m_tdata <= {5'd0, emit_held, emit_y, emit_x};
    end
    if (accept) begin
      x_r    <= s_tdata[23:12];
      y_r    <= s_tdata[35:24];
      cur    <= low_bucket;
      if (s_tuser[0] == OP_POP) err_r <= ST_EMPTY;
      else err_r <= ST_BAD_PRIO;
    end
    if (state == Q_PUSH_LOOK) begin
      id_r      <= tab_rsp.id;
      from_free <= !free_head[SLOT_W];
      slot_r    <= free_head[SLOT_W] ? fresh_next[SLOT_W-1:0] : free_head[SLOT_W-1:0];
      err_r     <= tab_rsp.valid ? ST_FULL : ST_BAD_PRIO;
    end
    if (state == Q_POP_SCAN) begin
      word_r <= bmp_q;
      if (fs.found) cur <= {cur[BKT_W-1:BIT_W], fs.idx};
      else cur <= {cur[BKT_W-1:BIT_W] + 1'b1, BIT_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (bmp_we) bmp_mem[bmp_wa] <= bmp_wd;
    if (bmp_re) bmp_q <= bmp_mem[bmp_ra];
  end

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    if (bkt_re) bkt_q <= bkt_mem[bkt_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (pts_we) pts_mem[pts_wa] <= {y_r, x_r};
    if (pts_re) pts_q <= pts_mem[pop_head];
  end

  `SDBQ_ASSERT_NEVER(a_held_bound, clk, rst, held_count > CNT_W'(CAPACITY))
  `SDBQ_ASSERT_IMPLY(a_empty_held, clk, rst, m_tvalid && m_tuser == ST_EMPTY, m_tdata[34:24] == '0)
  `SDBQ_ASSERT_IMPLY(a_err_zero, clk, rst, m_tvalid && m_tuser != ST_OK, m_tdata[23:0] == '0)
  `SDBQ_ASSERT_IMPLY(a_pop_nonempty, clk, rst, state == Q_POP_SCAN, held_count != '0)

endmodule
`default_nettype wire
